[rtl/sierpinski_tetrahedron_raymarcher_assert.svh]
// Assertion macros for the raymarcher RTL.
// Needs a clock named clock and a reset named reset in the using scope.
`ifndef SIERPINSKI_TETRAHEDRON_RAYMARCHER_ASSERT_SVH
`define SIERPINSKI_TETRAHEDRON_RAYMARCHER_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define STR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Implication checked on every clock edge outside reset.
`define STR_ASSERT_IMP(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) else $error(msg);

`endif

[rtl/str_pkg.sv]
// Shared types, constants and functions of the tetrahedron raymarcher.
// No dependencies.
`default_nettype none

package str_pkg;

   localparam int FOLD_ITERATIONS = 10;
   localparam int FRAC_BITS = 20;
   localparam int FOLD_W = $clog2(FOLD_ITERATIONS + 1);

   localparam int COORD_W = 32;
   localparam int R_W = 40;
   localparam int MUL_W = COORD_W + 1;
   localparam int PROD_W = 2 * MUL_W;

   localparam int SQRT_STEPS = (R_W + FRAC_BITS + 1) / 2;
   localparam int ROOT_W = SQRT_STEPS;

   localparam longint SCALE_Q = (13 * (64'sd1 <<< FRAC_BITS) + 5) / 10;
   localparam longint OFFS_Q = (3 * (64'sd1 <<< FRAC_BITS) + 5) / 10;
   localparam longint TWO_Q = 64'sd2 <<< FRAC_BITS;

   localparam logic signed [COORD_W-1:0] INT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] INT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   // register indexes on the csr channel
   localparam logic [1:0] CSR_STEP_LIMIT = 2'd0;
   localparam logic [1:0] CSR_HIT_THRESH = 2'd1;
   localparam logic [1:0] CSR_BAILOUT = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_POINT,
      ST_RADIUS,
      ST_RCHECK,
      ST_FOLD,
      ST_SCALE,
      ST_SQRT,
      ST_DMUL,
      ST_DSHIFT,
      ST_UPDATE,
      ST_DIV,
      ST_OUT
   } state_type;

   // 1.3^-i in unsigned Q0.32; entry 0 (exactly 1.0) is handled apart
   typedef logic [31:0] pw_table_type [FOLD_ITERATIONS + 1];

   function automatic pw_table_type pw_build();
      pw_table_type tbl;
      logic [63:0] w;
      w = 64'd1 << 32;
      tbl[0] = '0;
      for (int i = 1; i <= FOLD_ITERATIONS; i++) begin
         w = (w * 64'd10 + 64'd6) / 64'd13;
         tbl[i] = w[31:0];
      end
      return tbl;
   endfunction

   localparam pw_table_type PW_TABLE = pw_build();

   function automatic logic signed [COORD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
      logic signed [COORD_W-1:0] res;
      if (v > PROD_W'(signed'(INT_MAX))) res = INT_MAX;
      else if (v < PROD_W'(signed'(INT_MIN))) res = INT_MIN;
      else res = v[COORD_W-1:0];
      return res;
   endfunction

   function automatic logic signed [COORD_W-1:0] neg_sat(input logic signed [COORD_W-1:0] v);
      logic signed [COORD_W-1:0] res;
      if (v == INT_MIN) res = INT_MAX;
      else res = -v;
      return res;
   endfunction

endpackage

`default_nettype wire

[rtl/str_if.sv]
// Channel interfaces: ray requests, results and register writes.
// Uses str_pkg for widths.
`default_nettype none

interface str_req_if;
   logic valid;
   logic ready;
   logic signed [str_pkg::COORD_W-1:0] origin_x;
   logic signed [str_pkg::COORD_W-1:0] origin_y;
   logic signed [str_pkg::COORD_W-1:0] origin_z;
   logic signed [str_pkg::COORD_W-1:0] dir_x;
   logic signed [str_pkg::COORD_W-1:0] dir_y;
   logic signed [str_pkg::COORD_W-1:0] dir_z;
   modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                   input ready);
   modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                 output ready);
endinterface

interface str_rsp_if;
   logic valid;
   logic ready;
   logic [7:0] step_count;
   logic [16:0] shade;
   modport source (output valid, step_count, shade, input ready);
   modport sink (input valid, step_count, shade, output ready);
endinterface

interface str_csr_if;
   logic valid;
   logic ready;
   logic [1:0] index;
   logic [str_pkg::R_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/str_sqrt.sv]
// Bit-serial square root: root = floor(sqrt(r * 2^FRAC_BITS)), two radicand bits a cycle.
// Uses str_pkg.
`default_nettype none

module str_sqrt (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic [str_pkg::R_W-1:0] radius,
   output logic done,
   output logic [str_pkg::ROOT_W-1:0] root
);

   localparam int RAD_W = 2 * str_pkg::SQRT_STEPS;
   localparam int REM_W = str_pkg::ROOT_W + 4;
   localparam int CNT_W = $clog2(str_pkg::SQRT_STEPS);

   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [RAD_W-1:0] rad_ff, rad_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [str_pkg::ROOT_W-1:0] root_ff, root_in;

   logic [REM_W-1:0] rem_sh, trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rad_in = rad_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      rem_sh = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1:RAD_W-2]};
      trial = REM_W'({root_ff, 2'b01});
      if (start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         rad_in = RAD_W'({radius, {str_pkg::FRAC_BITS{1'b0}}});
         rem_in = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in = {rad_ff[RAD_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in = rem_sh - trial;
            root_in = {root_ff[str_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            root_in = {root_ff[str_pkg::ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(str_pkg::SQRT_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rad_ff <= rad_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

`default_nettype wire

[rtl/sierpinski_tetrahedron_raymarcher.sv]
// Tetrahedron ray marcher: one shared 33x33 multiplier and a sequencer; str_pkg, str_if, str_sqrt.
// Per march step: point, radius and check, then for each fold a fold, scale, radius and check,
// a wait on the root, the distance multiply (plus a shift when any fold ran) and the update.
// After the march a restoring divide in ST_DIV, then the result holds in ST_OUT until rsp_ch.ready.
// One ray at a time: req_ch.ready only in idle, and ST_IDLE lies between two rays.
// Reset: synchronous; step limit 100, hit threshold 105, bailout 1048576000.
`default_nettype none
`include "sierpinski_tetrahedron_raymarcher_assert.svh"

module sierpinski_tetrahedron_raymarcher (
   input wire logic clock,
   input wire logic reset,
   str_req_if.sink req_ch,
   str_rsp_if.source rsp_ch,
   str_csr_if.sink csr_ch
);

   localparam int CW = str_pkg::COORD_W;
   localparam int PW = str_pkg::PROD_W;

   str_pkg::state_type state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [str_pkg::FOLD_W-1:0] fold_ff, fold_in;
   logic [7:0] steps_ff, steps_in;
   logic signed [CW-1:0] org_ff [3], org_in [3];
   logic signed [CW-1:0] dir_ff [3], dir_in [3];
   logic signed [CW-1:0] p_ff [3], p_in [3];
   logic signed [CW-1:0] t_ff, t_in, dist_ff, dist_in, d_ff, d_in;
   logic [63:0] acc_ff, acc_in;
   logic [23:0] quo_ff, quo_in;
   logic [7:0] drem_ff, drem_in;
   logic [7:0] step_limit_ff;
   logic [20:0] hit_thresh_ff;
   logic [str_pkg::R_W-1:0] bailout_ff;
   logic [7:0] step_out_ff, step_out_in;
   logic [16:0] shade_ff, shade_in;
   logic signed [PW-1:0] prod_ff;

   logic signed [str_pkg::MUL_W-1:0] mul_a, mul_b;
   logic [1:0] kc, kp;
   logic signed [CW-1:0] op_p, op_dir, op_org;
   logic signed [PW-1:0] wide;
   logic signed [CW-1:0] res;
   logic [str_pkg::R_W-1:0] radius;
   logic [63:0] acc_sh;
   logic sq_start, sq_done;
   logic [str_pkg::ROOT_W-1:0] sq_root;
   logic [8:0] rem_sh;
   logic signed [CW:0] pair_sum;
   logic signed [CW-1:0] fa, fb;

   str_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .radius (radius),
      .done (sq_done),
      .root (sq_root)
   );

   assign kc = cnt_ff[1:0];
   assign kp = cnt_ff[1:0] - 2'd1;

   assign acc_sh = acc_ff >> str_pkg::FRAC_BITS;
   assign radius = (acc_sh > 64'(str_pkg::R_W'('1))) ? '1 : acc_sh[str_pkg::R_W-1:0];

   // operand pick for the current lane and the lane whose product is back
   always_comb begin
      case (kc)
         2'd0: begin op_p = p_ff[0]; op_dir = dir_ff[0]; end
         2'd1: begin op_p = p_ff[1]; op_dir = dir_ff[1]; end
         default: begin op_p = p_ff[2]; op_dir = dir_ff[2]; end
      endcase
      case (kp)
         2'd0: op_org = org_ff[0];
         2'd1: op_org = org_ff[1];
         default: op_org = org_ff[2];
      endcase
   end

   // shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         str_pkg::ST_POINT: begin
            mul_a = str_pkg::MUL_W'(t_ff);
            mul_b = str_pkg::MUL_W'(op_dir);
         end
         str_pkg::ST_RADIUS: begin
            mul_a = str_pkg::MUL_W'(op_p);
            mul_b = str_pkg::MUL_W'(op_p);
         end
         str_pkg::ST_SCALE: begin
            mul_a = str_pkg::MUL_W'(op_p);
            mul_b = str_pkg::MUL_W'(str_pkg::SCALE_Q);
         end
         str_pkg::ST_DMUL: begin
            mul_a = str_pkg::MUL_W'(d_ff);
            mul_b = signed'({1'b0, str_pkg::PW_TABLE[fold_ff]});
         end
         default: ;
      endcase
   end

   // fold pair pick: (x,y), (x,z), (y,z)
   always_comb begin
      case (cnt_ff[1:0])
         2'd0: begin fa = p_ff[0]; fb = p_ff[1]; end
         2'd1: begin fa = p_ff[0]; fb = p_ff[2]; end
         default: begin fa = p_ff[1]; fb = p_ff[2]; end
      endcase
      pair_sum = (CW+1)'(fa) + (CW+1)'(fb);
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      fold_in = fold_ff;
      steps_in = steps_ff;
      org_in = org_ff;
      dir_in = dir_ff;
      p_in = p_ff;
      t_in = t_ff;
      dist_in = dist_ff;
      d_in = d_ff;
      acc_in = acc_ff;
      quo_in = quo_ff;
      drem_in = drem_ff;
      step_out_in = step_out_ff;
      shade_in = shade_ff;
      sq_start = 1'b0;
      wide = '0;
      res = '0;
      rem_sh = '0;

      case (state_ff)
         str_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               org_in[0] = req_ch.origin_x;
               org_in[1] = req_ch.origin_y;
               org_in[2] = req_ch.origin_z;
               dir_in[0] = req_ch.dir_x;
               dir_in[1] = req_ch.dir_y;
               dir_in[2] = req_ch.dir_z;
               t_in = '0;
               steps_in = '0;
               cnt_in = '0;
               fold_in = '0;
               if (step_limit_ff == 8'd0) begin
                  quo_in = '0;
                  drem_in = '0;
                  state_in = str_pkg::ST_DIV;
               end else begin
                  state_in = str_pkg::ST_POINT;
               end
            end
         end
         str_pkg::ST_POINT: begin
            // p = org + floor(t*dir >> F), both saturated
            if (cnt_ff != 5'd0) begin
               wide = prod_ff >>> str_pkg::FRAC_BITS;
               res = str_pkg::sat32(PW'(op_org) + PW'(str_pkg::sat32(wide)));
               for (int j = 0; j < 3; j++) if (kp == 2'(j)) p_in[j] = res;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 5'd3) begin
               cnt_in = '0;
               fold_in = '0;
               state_in = str_pkg::ST_RADIUS;
            end
         end
         str_pkg::ST_RADIUS: begin
            if (cnt_ff == 5'd0) acc_in = '0;
            else acc_in = acc_ff + prod_ff[63:0];
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 5'd3) begin
               cnt_in = '0;
               state_in = str_pkg::ST_RCHECK;
            end
         end
         str_pkg::ST_RCHECK: begin
            if (fold_ff < str_pkg::FOLD_W'(str_pkg::FOLD_ITERATIONS) &&
                radius < bailout_ff) begin
               state_in = str_pkg::ST_FOLD;
            end else begin
               sq_start = 1'b1;
               state_in = str_pkg::ST_SQRT;
            end
         end
         str_pkg::ST_FOLD: begin
            if (pair_sum < 0) begin
               case (cnt_ff[1:0])
                  2'd0: begin
                     p_in[0] = str_pkg::neg_sat(fb);
                     p_in[1] = str_pkg::neg_sat(fa);
                  end
                  2'd1: begin
                     p_in[0] = str_pkg::neg_sat(fb);
                     p_in[2] = str_pkg::neg_sat(fa);
                  end
                  default: begin
                     p_in[1] = str_pkg::neg_sat(fb);
                     p_in[2] = str_pkg::neg_sat(fa);
                  end
               endcase
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 5'd2) begin
               cnt_in = '0;
               state_in = str_pkg::ST_SCALE;
            end
         end
         str_pkg::ST_SCALE: begin
            // c' = floor((c*S + half) >> F) - OFFS
            if (cnt_ff != 5'd0) begin
               wide = (prod_ff + PW'(64'sd1 <<< (str_pkg::FRAC_BITS - 1)))
                      >>> str_pkg::FRAC_BITS;
               res = str_pkg::sat32(wide - PW'(str_pkg::OFFS_Q));
               for (int j = 0; j < 3; j++) if (kp == 2'(j)) p_in[j] = res;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 5'd3) begin
               cnt_in = '0;
               fold_in = fold_ff + 1'b1;
               state_in = str_pkg::ST_RADIUS;
            end
         end
         str_pkg::ST_SQRT: begin
            if (sq_done) begin
               d_in = CW'(signed'({1'b0, sq_root})) - CW'(str_pkg::TWO_Q);
               state_in = str_pkg::ST_DMUL;
            end
         end
         str_pkg::ST_DMUL: begin
            if (fold_ff == '0) begin
               dist_in = d_ff;
               state_in = str_pkg::ST_UPDATE;
            end else begin
               state_in = str_pkg::ST_DSHIFT;
            end
         end
         str_pkg::ST_DSHIFT: begin
            dist_in = str_pkg::sat32(prod_ff >>> 32);
            state_in = str_pkg::ST_UPDATE;
         end
         str_pkg::ST_UPDATE: begin
            t_in = str_pkg::sat32(PW'(t_ff) + PW'(dist_ff));
            quo_in = '0;
            drem_in = '0;
            cnt_in = '0;
            if (dist_ff < signed'({11'd0, hit_thresh_ff})) begin
               state_in = str_pkg::ST_DIV;
            end else begin
               steps_in = steps_ff + 1'b1;
               if (steps_ff + 8'd1 < step_limit_ff) state_in = str_pkg::ST_POINT;
               else state_in = str_pkg::ST_DIV;
            end
         end
         str_pkg::ST_DIV: begin
            // restoring divide of steps*65536 by the step limit, one bit a cycle
            if (cnt_ff == 5'd0) begin
               quo_in = {steps_ff, 16'd0};
               drem_in = '0;
               cnt_in = 5'd1;
            end else begin
               rem_sh = {drem_ff, quo_ff[23]};
               if (rem_sh >= {1'b0, step_limit_ff}) begin
                  drem_in = 8'(rem_sh - {1'b0, step_limit_ff});
                  quo_in = {quo_ff[22:0], 1'b1};
               end else begin
                  drem_in = rem_sh[7:0];
                  quo_in = {quo_ff[22:0], 1'b0};
               end
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == 5'd24) begin
                  cnt_in = '0;
                  state_in = str_pkg::ST_OUT;
               end
            end
         end
         str_pkg::ST_OUT: begin
            if (rsp_ch.ready) state_in = str_pkg::ST_IDLE;
         end
         default: state_in = str_pkg::ST_IDLE;
      endcase

      if (state_ff == str_pkg::ST_DIV && state_in == str_pkg::ST_OUT) begin
         step_out_in = steps_ff;
         if (step_limit_ff == 8'd0) shade_in = 17'd65536;
         else shade_in = 17'd65536 - quo_in[16:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= str_pkg::ST_IDLE;
         cnt_ff <= '0;
         step_limit_ff <= 8'd100;
         hit_thresh_ff <= 21'd105;
         bailout_ff <= 40'd1048576000;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         if (csr_ch.valid) begin
            case (csr_ch.index)
               str_pkg::CSR_STEP_LIMIT: step_limit_ff <= csr_ch.data[7:0];
               str_pkg::CSR_HIT_THRESH: hit_thresh_ff <= csr_ch.data[20:0];
               str_pkg::CSR_BAILOUT: bailout_ff <= csr_ch.data;
               default: ;
            endcase
         end
      end
      fold_ff <= fold_in;
      steps_ff <= steps_in;
      org_ff <= org_in;
      dir_ff <= dir_in;
      p_ff <= p_in;
      t_ff <= t_in;
      dist_ff <= dist_in;
      d_ff <= d_in;
      acc_ff <= acc_in;
      quo_ff <= quo_in;
      drem_ff <= drem_in;
      step_out_ff <= step_out_in;
      shade_ff <= shade_in;
      prod_ff <= mul_a * mul_b;
   end

   assign req_ch.ready = (state_ff == str_pkg::ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign rsp_ch.valid = (state_ff == str_pkg::ST_OUT);
   assign rsp_ch.step_count = step_out_ff;
   assign rsp_ch.shade = shade_ff;

   `STR_ASSERT(a_no_overlap, !(req_ch.ready && rsp_ch.valid), "ready with result pending")
   `STR_ASSERT_IMP(a_steps, rsp_ch.valid, rsp_ch.step_count <= step_limit_ff, "steps over limit")
   `STR_ASSERT_IMP(a_shade, rsp_ch.valid, rsp_ch.shade <= 17'd65536, "shade above one")
   `STR_ASSERT_IMP(a_sqrt_wait, sq_done, state_ff == str_pkg::ST_SQRT, "root done early")

endmodule

`default_nettype wire

[tb/tb_sierpinski_tetrahedron_raymarcher.sv]
// Self-checking testbench for the raymarcher: rays in, step count and shade out.
// Each accepted ray is checked against a fixed-point predictor of the march or a given result.
// Depends on str_pkg, str_if and the raymarcher RTL.
`timescale 1ns / 100ps

module tb_sierpinski_tetrahedron_raymarcher;

   localparam longint ONE = 64'sd1 <<< str_pkg::FRAC_BITS;
   localparam int UNIT = 1 << str_pkg::FRAC_BITS;
   localparam longint LIMIT_CYCLES = 4_000_000;
   localparam logic [39:0] R_SAT = 40'hFF_FFFF_FFFF;

   typedef struct {
      logic signed [str_pkg::COORD_W-1:0] ox, oy, oz, dx, dy, dz;
   } ray_type;

   typedef struct {
      logic [7:0] steps;
      logic [16:0] shade;
   } result_type;

   typedef struct {
      int phase;
      ray_type ray;
      bit known;
      result_type res;
   } row_type;

   typedef struct {
      logic [7:0] step_limit;
      logic [20:0] hit_thresh;
      logic [39:0] bailout;
   } cfg_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   str_req_if req_ch();
   str_rsp_if rsp_ch();
   str_csr_if csr_ch();

   sierpinski_tetrahedron_raymarcher dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   // predictor copy of the registers
   cfg_type cur_cfg = '{8'd100, 21'd105, 40'd1048576000};
   longint inv_scale [str_pkg::FOLD_ITERATIONS + 1];

   result_type pending_results [$];
   int errors = 0;
   longint cycles = 0;
   int burst_left = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      inv_scale[0] = 64'sd1 <<< 32;
      for (int i = 1; i <= str_pkg::FOLD_ITERATIONS; i++)
         inv_scale[i] = (inv_scale[i-1] * 10 + 6) / 13;
   end

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic logic [39:0] radius2(longint p [3]);
      logic [63:0] s;
      s = '0;
      for (int k = 0; k < 3; k++) s = s + 64'(p[k] * p[k]);
      s = s >> str_pkg::FRAC_BITS;
      return (s > 64'(R_SAT)) ? R_SAT : s[39:0];
   endfunction

   function automatic longint root_q(logic [39:0] r);
      logic [63:0] op, res, bitv;
      op = 64'(r) << str_pkg::FRAC_BITS;
      res = '0;
      bitv = 64'd1 << 62;
      while (bitv > op) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (op >= res + bitv) begin
            op = op - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return (res > 64'd2147483647) ? 64'sd2147483647 : longint'(res);
   endfunction

   function automatic longint tetra_distance(longint p [3]);
      logic [39:0] r;
      longint tmp, d;
      int i;
      r = radius2(p);
      for (i = 0; i < str_pkg::FOLD_ITERATIONS && r < cur_cfg.bailout; i++) begin
         if (p[0] + p[1] < 0) begin
            tmp = clamp32(-p[1]); p[1] = clamp32(-p[0]); p[0] = tmp;
         end
         if (p[0] + p[2] < 0) begin
            tmp = clamp32(-p[2]); p[2] = clamp32(-p[0]); p[0] = tmp;
         end
         if (p[1] + p[2] < 0) begin
            tmp = clamp32(-p[2]); p[2] = clamp32(-p[1]); p[1] = tmp;
         end
         for (int k = 0; k < 3; k++)
            p[k] = clamp32(((p[k] * str_pkg::SCALE_Q + (ONE >>> 1)) >>> str_pkg::FRAC_BITS)
                           - str_pkg::OFFS_Q);
         r = radius2(p);
      end
      d = root_q(r) - str_pkg::TWO_Q;
      return clamp32((d * inv_scale[i]) >>> 32);
   endfunction

   function automatic result_type march_ray(ray_type ray);
      longint org [3], dir [3], p [3];
      longint t, est;
      int steps;
      result_type res;
      org = '{longint'(ray.ox), longint'(ray.oy), longint'(ray.oz)};
      dir = '{longint'(ray.dx), longint'(ray.dy), longint'(ray.dz)};
      t = 0;
      for (steps = 0; steps < cur_cfg.step_limit; steps++) begin
         for (int k = 0; k < 3; k++)
            p[k] = clamp32(org[k] + clamp32((t * dir[k]) >>> str_pkg::FRAC_BITS));
         est = tetra_distance(p);
         t = clamp32(t + est);
         if (est < longint'(cur_cfg.hit_thresh)) break;
      end
      res.steps = 8'(steps);
      if (cur_cfg.step_limit == 0) res.shade = 17'd65536;
      else res.shade = 17'(65536 - (steps * 65536) / cur_cfg.step_limit);
      return res;
   endfunction

   task automatic write_reg(logic [1:0] idx, logic [39:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= value;
      do @(posedge clock); while (!(csr_ch.valid && csr_ch.ready));
   endtask

   task automatic drain();
      while (pending_results.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic load_cfg(cfg_type c);
      drain();
      write_reg(str_pkg::CSR_STEP_LIMIT, 40'(c.step_limit));
      write_reg(str_pkg::CSR_HIT_THRESH, 40'(c.hit_thresh));
      write_reg(str_pkg::CSR_BAILOUT, c.bailout);
      csr_ch.valid <= 1'b0;
      cur_cfg = c;
   endtask

   task automatic send_ray(ray_type ray, bit known, result_type typed);
      req_ch.valid <= 1'b1;
      req_ch.origin_x <= ray.ox;
      req_ch.origin_y <= ray.oy;
      req_ch.origin_z <= ray.oz;
      req_ch.dir_x <= ray.dx;
      req_ch.dir_y <= ray.dy;
      req_ch.dir_z <= ray.dz;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      pending_results.push_back(known ? typed : march_ray(ray));
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 5);
         if ($urandom_range(0, 3) != 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
   endtask

   function automatic logic signed [31:0] near_coord(int range_q);
      return 32'(int'($urandom_range(0, 32'(2 * range_q))) - range_q);
   endfunction

   function automatic ray_type random_ray();
      ray_type r;
      if ($urandom_range(0, 4) == 0) begin
         r = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      end else begin
         // origin coordinates within 4 units, direction components within one unit
         r.ox = near_coord(4 * UNIT); r.oy = near_coord(4 * UNIT);
         r.oz = near_coord(4 * UNIT);
         r.dx = near_coord(UNIT); r.dy = near_coord(UNIT); r.dz = near_coord(UNIT);
      end
      return r;
   endfunction

   // receiver: rsp_ch.ready follows one of four stall modes, redrawn at random on a regular period
   logic [1:0] stall_mode = 2'd0;
   always @(posedge clock) begin
      if (cycles % 64 == 0) stall_mode <= 2'($urandom_range(0, 3));
      case (stall_mode)
         2'd0: rsp_ch.ready <= 1'b1;
         2'd1: rsp_ch.ready <= 1'($urandom_range(0, 1));
         2'd2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ch.ready <= (cycles % 8) < 5;
      endcase
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result transfer: step_count %0d shade %0d",
                   rsp_ch.step_count, rsp_ch.shade);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.step_count !== want.steps) begin
               $error("step_count: expected %0d, got %0d", want.steps, rsp_ch.step_count);
               errors++;
            end
            if (rsp_ch.shade !== want.shade) begin
               $error("shade: expected %0d, got %0d", want.shade, rsp_ch.shade);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("Mismatches found");
         $finish;
      end
   end

   cfg_type phase_cfg [5] = '{
      '{8'd100, 21'd105, 40'd1048576000},         // after reset, not written
      '{8'd0, 21'd105, 40'd1048576000},           // no steps at all
      '{8'd255, 21'd1048576, 40'hFF_FFFF_FFFF},   // highest step limit and bailout
      '{8'd1, 21'd0, 40'd0},                      // no folds, hit only below zero
      '{8'd20, 21'd1, 40'd1}
   };

   localparam logic signed [31:0] P1 = 32'sd1048576;
   localparam logic signed [31:0] N1 = -32'sd1048576;
   localparam logic signed [31:0] PMAX = str_pkg::INT_MAX;
   localparam logic signed [31:0] NMIN = str_pkg::INT_MIN;
   localparam result_type NO_STEPS = '{8'd0, 17'd65536};
   localparam result_type NONE = '{8'd0, 17'd0};

   row_type dir_table [20] = '{
      '{0, '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 0, NONE},
      '{0, '{32'sd0, 32'sd0, -3 * P1, 32'sd0, 32'sd0, P1}, 0, NONE},
      '{0, '{P1, P1, P1, N1, N1, N1}, 0, NONE},
      '{0, '{PMAX, PMAX, PMAX, PMAX, PMAX, PMAX}, 0, NONE},
      '{0, '{NMIN, NMIN, NMIN, NMIN, NMIN, NMIN}, 0, NONE},
      '{0, '{NMIN, PMAX, NMIN, PMAX, NMIN, PMAX}, 0, NONE},
      '{0, '{100 * P1, 100 * P1, 100 * P1, P1, P1, P1}, 0, NONE},
      '{1, '{32'sd0, 32'sd0, 32'sd0, P1, P1, P1}, 1, NO_STEPS},
      '{1, '{PMAX, NMIN, PMAX, NMIN, PMAX, NMIN}, 1, NO_STEPS},
      '{1, '{32'hFFFFFFFF, 32'sd0, 32'hFFFFFFFF, 32'sd0, 32'sd1, N1}, 1, NO_STEPS},
      '{2, '{32'sd0, 32'sd0, -3 * P1, 32'sd0, 32'sd0, P1}, 0, NONE},
      '{2, '{PMAX, PMAX, PMAX, PMAX, PMAX, PMAX}, 0, NONE},
      '{2, '{NMIN, NMIN, NMIN, NMIN, NMIN, NMIN}, 0, NONE},
      '{2, '{P1 / 2, -P1 / 4, P1 / 8, P1 / 3, N1 / 5, P1}, 0, NONE},
      '{3, '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 0, NONE},
      '{3, '{32'sd1, 32'sd1, 32'sd1, 32'sd1, 32'sd1, 32'sd1}, 0, NONE},
      '{3, '{NMIN, NMIN, NMIN, PMAX, PMAX, PMAX}, 0, NONE},
      '{4, '{-2 * P1, 3 * P1, -P1, P1, N1, P1}, 0, NONE},
      '{4, '{PMAX, 32'sd0, NMIN, N1, 32'sd0, P1}, 0, NONE},
      '{4, '{5 * P1, 5 * P1, 5 * P1, N1, N1, N1}, 0, NONE}
   };

   initial begin
      cfg_type c;
      int cur_phase;
      req_ch.valid = 1'b0;
      req_ch.origin_x = '0; req_ch.origin_y = '0; req_ch.origin_z = '0;
      req_ch.dir_x = '0; req_ch.dir_y = '0; req_ch.dir_z = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = str_pkg::CSR_STEP_LIMIT;
      csr_ch.data = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      cur_phase = 0;
      foreach (dir_table[n]) begin
         if (dir_table[n].phase != cur_phase) begin
            req_ch.valid <= 1'b0;
            cur_phase = dir_table[n].phase;
            load_cfg(phase_cfg[cur_phase]);
         end
         send_ray(dir_table[n].ray, dir_table[n].known, dir_table[n].res);
      end
      req_ch.valid <= 1'b0;

      for (int ph = 0; ph < 6; ph++) begin
         c.step_limit = 8'($urandom_range(1, 16));
         c.hit_thresh = ($urandom_range(0, 1) == 1) ? 21'($urandom_range(1, 2000))
                                                   : 21'($urandom_range(1, 1048576));
         case ($urandom_range(0, 2))
            0: c.bailout = 40'd1048576000;
            1: c.bailout = 40'($urandom_range(1, 200_000_000));
            default: c.bailout = 40'({$urandom, $urandom});
         endcase
         load_cfg(c);
         repeat (22) send_ray(random_ray(), 1'b0, NONE);
         req_ch.valid <= 1'b0;
      end

      drain();
      if (errors == 0 && pending_results.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl
rtl/str_pkg.sv
rtl/str_if.sv
rtl/str_sqrt.sv
rtl/sierpinski_tetrahedron_raymarcher.sv
tb/tb_sierpinski_tetrahedron_raymarcher.sv
